// ----- rtl/ptse_pkg.sv -----
// ----------------------------------------------------------------------------
// Polynomial term store package
// Shared widths, codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ptse_pkg;

    // Default table depth; the top level hands its parameter down.
    localparam int NUM_COEFFS_DEF = 16;

    // Field widths of the request and result channels.
    localparam int CMD_W   = 1;
    localparam int EXP_W   = 8;
    localparam int COEF_W  = 32;
    localparam int X_W     = 32;
    localparam int VALUE_W = 48;
    localparam int STAT_W  = 2;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_EVAL = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OOR = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SAT = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted request
        logic oor_result;  // post an out-of-range result
        logic add_read;    // read the addressed table entry
        logic add_update;  // saturating add and write back
        logic mul_step;    // register the Horner partial products
        logic acc_step;    // fold the products and the coefficient in
        logic out_load;    // move the result into the output register
    } ptse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_eval;     // request on the input is an evaluate
        logic in_oor;      // request exponent lies beyond the table
        logic idx_zero;    // Horner index has reached the constant term
        logic out_free;    // output register can take a result
    } ptse_stat_t;

endpackage

// ----- rtl/polynomial_term_store_evaluate_top.sv -----
// ----------------------------------------------------------------------------
// Polynomial term store and evaluator
// Dense coefficient table with saturating term add and Horner evaluation of
// the polynomial at a signed Q16.16 point, giving a saturated Q32.16 value.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid / s_ready  s_cmd, s_exponent, s_coefficient,
//                                          s_x_value
//   m_       out        m_valid / m_ready  m_value, m_status
//
// An evaluate request steps through the table from the highest coefficient
// down: for each one a multiply state registers the two partial products and
// an accumulate state does the round, add and clamp. An add request reads the
// entry and writes back the sum; an out-of-range add goes straight to its result.
// Reset clears the table at once through per-entry written flags.
// A result waits in its finishing state while the output register is full.
// ----------------------------------------------------------------------------
module polynomial_term_store_evaluate_top
    import ptse_pkg::*;
#(
    parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CMD_W-1:0]          s_cmd,
    input  logic [EXP_W-1:0]          s_exponent,
    input  logic signed [COEF_W-1:0]  s_coefficient,
    input  logic signed [X_W-1:0]     s_x_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value,
    output logic [STAT_W-1:0]         m_status
);

    ptse_cmd_t  cmd;
    ptse_stat_t stat;

    // Request sequencing.
    ptse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Table, arithmetic and output register.
    ptse_dp #(
        .NUM_COEFFS (NUM_COEFFS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_cmd         (s_cmd),
        .s_exponent    (s_exponent),
        .s_coefficient (s_coefficient),
        .s_x_value     (s_x_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_status      (m_status),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ----- rtl/ptse_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ptse_ctrl.sv -----
// ----------------------------------------------------------------------------
// Polynomial term store controller
// Sequences add and evaluate requests through the datapath, one at a time.
// ----------------------------------------------------------------------------
module ptse_ctrl
    import ptse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ptse_stat_t stat,
    output ptse_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD_RD = 3'd1;
    localparam logic [2:0] ST_ADD_WR = 3'd2;
    localparam logic [2:0] ST_EV_MUL = 3'd3;
    localparam logic [2:0] ST_EV_ACC = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (stat.in_eval) begin
                        state_next = ST_EV_MUL;
                    end else if (stat.in_oor) begin
                        cmd.oor_result = 1'b1;
                        state_next     = ST_RESP;
                    end else begin
                        state_next = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD: begin
                cmd.add_read = 1'b1;
                state_next   = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                cmd.add_update = 1'b1;
                state_next     = ST_RESP;
            end
            ST_EV_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = ST_EV_ACC;
            end
            ST_EV_ACC: begin
                cmd.acc_step = 1'b1;
                state_next   = stat.idx_zero ? ST_RESP : ST_EV_MUL;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ptse_dp.sv -----
// ----------------------------------------------------------------------------
// Polynomial term store datapath
// Coefficient table, saturating term add, Horner multiply-accumulate and the
// output register.
// ----------------------------------------------------------------------------
module ptse_dp
    import ptse_pkg::*;
#(
    parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [CMD_W-1:0]          s_cmd,
    input  logic [EXP_W-1:0]          s_exponent,
    input  logic signed [COEF_W-1:0]  s_coefficient,
    input  logic signed [X_W-1:0]     s_x_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value,
    output logic [STAT_W-1:0]         m_status,
    input  ptse_cmd_t                 cmd,
    output ptse_stat_t                stat
);

    localparam int IDX_W  = $clog2(NUM_COEFFS);
    localparam int PROD_W = 56;

    // Captured request fields.
    logic [IDX_W-1:0]  exp_idx_reg;
    logic [COEF_W-1:0] coeff_reg;
    logic [X_W-1:0]    x_mag_reg;
    logic              x_neg_reg;

    // Horner state.
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VALUE_W-1:0] acc_reg;
    logic                    sat_reg;
    logic [PROD_W-1:0]       p_hi_reg;
    logic [PROD_W-1:0]       p_lo_reg;
    logic                    neg_reg;

    // Pending result and output register.
    logic [VALUE_W-1:0] res_value_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_value_reg;
    logic [STAT_W-1:0]  m_status_reg;

    // Entry written flags; an unwritten entry reads as zero.
    logic [NUM_COEFFS-1:0] valid_reg;

    logic [IDX_W-1:0]  ram_raddr;
    logic [COEF_W-1:0] ram_rdata;
    logic              ram_we;
    logic [COEF_W-1:0] ram_wdata;

    // Status toward the controller.
    assign stat.in_eval  = (s_cmd == CMD_EVAL);
    assign stat.in_oor   = ({1'b0, s_exponent} >= (EXP_W + 1)'(NUM_COEFFS));
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    // Coefficient table.
    assign ram_raddr = cmd.add_read ? exp_idx_reg : idx_reg;

    ptse_ram #(
        .WIDTH (COEF_W),
        .DEPTH (NUM_COEFFS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (exp_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Magnitude of the evaluation point.
    logic [X_W-1:0] x_mag_in;
    assign x_mag_in = s_x_value[X_W-1] ? (~s_x_value + 1'b1) : s_x_value;

    // Saturating add of a term into its entry.
    logic [COEF_W-1:0]        old_coef;
    logic signed [COEF_W:0]   add_sum;
    logic                     add_ovf;
    logic [COEF_W-1:0]        add_clamp;

    assign old_coef  = valid_reg[exp_idx_reg] ? ram_rdata : '0;
    assign add_sum   = $signed({old_coef[COEF_W-1], old_coef})
                     + $signed({coeff_reg[COEF_W-1], coeff_reg});
    assign add_ovf   = add_sum[COEF_W] != add_sum[COEF_W-1];
    assign add_clamp = add_ovf ? {add_sum[COEF_W], {(COEF_W-1){~add_sum[COEF_W]}}}
                               : add_sum[COEF_W-1:0];
    assign ram_we    = cmd.add_update;
    assign ram_wdata = add_clamp;

    // Partial products of |acc| * |x|, split at bit 24 of the accumulator.
    logic [VALUE_W-1:0] acc_mag;
    logic [23:0]        acc_hi;
    logic [23:0]        acc_lo;
    logic [PROD_W-1:0]  p_hi_next;
    logic [PROD_W-1:0]  p_lo_next;

    assign acc_mag   = acc_reg[VALUE_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign acc_hi    = acc_mag[47:24];
    assign acc_lo    = acc_mag[23:0];
    assign p_hi_next = acc_hi * x_mag_reg;
    assign p_lo_next = acc_lo * x_mag_reg;

    // Rounded product, clamp to 2^47, sign, coefficient add and 48-bit clamp.
    logic [PROD_W:0]         lo_rnd;
    logic [63:0]             m_full;
    logic                    m_big;
    logic [VALUE_W-1:0]      m_clamp;
    logic signed [49:0]      prod_s;
    logic [COEF_W-1:0]       eval_coef;
    logic signed [49:0]      term_s;
    logic signed [49:0]      sum_s;
    logic                    sum_hi;
    logic                    sum_lo;
    logic [VALUE_W-1:0]      acc_next;
    logic                    sat_next;

    assign lo_rnd    = {1'b0, p_lo_reg} + (PROD_W + 1)'(17'h08000);
    assign m_full    = {p_hi_reg, 8'd0} + 64'(lo_rnd[PROD_W:16]);
    assign m_big     = m_full > 64'h0000_8000_0000_0000;
    assign m_clamp   = m_big ? 48'h8000_0000_0000 : m_full[VALUE_W-1:0];
    assign prod_s    = neg_reg ? -$signed({2'b00, m_clamp}) : $signed({2'b00, m_clamp});
    assign eval_coef = valid_reg[idx_reg] ? ram_rdata : '0;
    assign term_s    = $signed({{2{eval_coef[COEF_W-1]}}, eval_coef, 16'd0});
    assign sum_s     = prod_s + term_s;
    assign sum_hi    = !sum_s[49] && (sum_s[48:47] != 2'b00);
    assign sum_lo    = sum_s[49] && (sum_s[48:47] != 2'b11);
    assign acc_next  = sum_hi ? 48'h7FFF_FFFF_FFFF :
                       sum_lo ? 48'h8000_0000_0000 : sum_s[VALUE_W-1:0];
    assign sat_next  = sat_reg || m_big || sum_hi || sum_lo;

    // Written flags are cleared by reset, which empties the table at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.add_update) begin
            valid_reg[exp_idx_reg] <= 1'b1;
        end
    end

    // Request capture and Horner registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            exp_idx_reg <= s_exponent[IDX_W-1:0];
            coeff_reg   <= s_coefficient;
            x_mag_reg   <= x_mag_in;
            x_neg_reg   <= s_x_value[X_W-1];
            idx_reg     <= IDX_W'(NUM_COEFFS - 1);
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
        end
        if (cmd.mul_step) begin
            p_hi_reg <= p_hi_next;
            p_lo_reg <= p_lo_next;
            neg_reg  <= acc_reg[VALUE_W-1] ^ x_neg_reg;
        end
        if (cmd.acc_step) begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
            idx_reg <= idx_reg - 1'b1;
        end
    end

    // Pending result.
    always_ff @(posedge aclk) begin
        if (cmd.oor_result) begin
            res_value_reg  <= '0;
            res_status_reg <= STATUS_OOR;
        end else if (cmd.add_update) begin
            res_value_reg  <= {{(VALUE_W-COEF_W){add_clamp[COEF_W-1]}}, add_clamp};
            res_status_reg <= add_ovf ? STATUS_SAT : STATUS_OK;
        end else if (cmd.acc_step) begin
            res_value_reg  <= acc_next;
            res_status_reg <= sat_next ? STATUS_SAT : STATUS_OK;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

endmodule

// ----- rtl/ptse_checker.sv -----
// ----------------------------------------------------------------------------
// Polynomial term store port checker
// Watches the top-level ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
module ptse_checker
    import ptse_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [VALUE_W-1:0] m_value,
    input logic [STAT_W-1:0]         m_status
);

    // One request at a time: the input closes right after an acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input stayed open after a request was accepted");

    // Only the defined status codes appear on a valid result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_OOR ||
                     m_status == STATUS_SAT))
        else $error("undefined result status");

    // An out-of-range result carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_OOR |-> m_value == '0)
        else $error("out-of-range result with a nonzero value");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("stalled result changed or dropped");

endmodule

bind polynomial_term_store_evaluate_top ptse_checker u_ptse_checker (.*);
